>>> hdl/key_sort_engine_top_assert.svh
// assertion macros for the key sort engine checker
`ifndef KEY_SORT_ENGINE_TOP_ASSERT_SVH
`define KEY_SORT_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define KSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define KSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/kse_pkg.sv
// shared constants, types and controller states of the key sort engine
`timescale 1ns / 1ps

package kse_pkg;

	localparam int MAX_KEYS = 64;
	localparam int KEY_BITS = 16;
	localparam int IDX_W    = $clog2(MAX_KEYS);
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// qualifies the key read back from the store in the scan stage
	typedef struct packed {
		logic vld;
		logic first;
		idx_t idx;
	} scan_ctl_t;

endpackage

>>> hdl/kse_ram.sv
// generic simple dual-port ram, one write and one registered read port
`timescale 1ns / 1ps

module kse_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/kse_scan.sv
// minimum tracker over the keys read back from the store during one pass
`timescale 1ns / 1ps

module kse_scan (
	input  logic               clk,
	input  kse_pkg::key_t      rd_data,
	input  kse_pkg::scan_ctl_t ctl,
	output kse_pkg::key_t      min_val,
	output kse_pkg::idx_t      min_idx,
	output kse_pkg::key_t      head_val
);
	import kse_pkg::*;

	key_t min_val_q;
	idx_t min_idx_q;
	key_t head_val_q;

	// first key of a pass seeds the minimum and is kept for the swap
	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			if (ctl.first) begin
				min_val_q  <= rd_data;
				min_idx_q  <= ctl.idx;
				head_val_q <= rd_data;
			end else if (rd_data < min_val_q) begin
				min_val_q <= rd_data;
				min_idx_q <= ctl.idx;
			end
		end
	end

	assign min_val  = min_val_q;
	assign min_idx  = min_idx_q;
	assign head_val = head_val_q;

endmodule

>>> hdl/key_sort_engine_top.sv
// key sort engine: stores a run of keys, then emits them in ascending order
// loading: one key per cycle, busy stays low until the key marked run_end
// sorting: selection passes over the store ram, one result per pass; each pass
//   scans the unsorted tail for its minimum and moves the head key into its slot
// the single read port of the store, one key per cycle, sets the pass length
// reset: async active low, store empty, loading, no result pending
`timescale 1ns / 1ps

module key_sort_engine_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  kse_pkg::key_t key_value,
	input  logic          run_end,
	output logic          result_valid,
	output kse_pkg::key_t sorted_value,
	output logic          sorted_end
);
	import kse_pkg::*;

	state_t    state_q, state_d;
	cnt_t      count_q;
	cnt_t      n_q;
	idx_t      pos_q;
	idx_t      rd_idx_q;
	scan_ctl_t ctl_s1;

	logic  accept;
	logic  store_room;
	logic  rd_last;
	logic  pos_last;
	logic  ram_we;
	idx_t  ram_waddr;
	key_t  ram_wdata;
	logic  ram_re;
	key_t  ram_rdata;
	key_t  min_val;
	idx_t  min_idx;
	key_t  head_val;
	idx_t  n_last;

	assign accept     = start && !busy;
	assign store_room = (count_q < cnt_t'(MAX_KEYS));
	assign n_last     = idx_t'(n_q - cnt_t'(1));
	assign rd_last    = (rd_idx_q == n_last);
	assign pos_last   = (pos_q == n_last);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && run_end) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				state_d = pos_last ? ST_LOAD : ST_SCAN;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// outputs and store port control
	always_comb begin
		busy      = 1'b1;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = key_value;
		unique case (state_q)
			ST_LOAD: begin
				busy   = 1'b0;
				ram_we = accept && store_room;
			end
			ST_SCAN: begin
				ram_re = 1'b1;
			end
			ST_DRAIN: begin
				ram_re = 1'b0;
			end
			ST_EMIT: begin
				// the head key moves into the slot the minimum leaves
				ram_we    = 1'b1;
				ram_waddr = min_idx;
				ram_wdata = head_val;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign result_valid = (state_q == ST_EMIT);
	assign sorted_end   = result_valid && pos_last;
	assign sorted_value = min_val;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			count_q  <= '0;
			n_q      <= '0;
			pos_q    <= '0;
			rd_idx_q <= '0;
			ctl_s1   <= '0;
		end else begin
			state_q <= state_d;
			// read pipeline tag lines up with the ram data
			ctl_s1.vld   <= (state_q == ST_SCAN);
			ctl_s1.first <= (rd_idx_q == pos_q);
			ctl_s1.idx   <= rd_idx_q;
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (run_end) begin
							n_q      <= store_room ? count_q + cnt_t'(1) : count_q;
							count_q  <= '0;
							pos_q    <= '0;
							rd_idx_q <= '0;
						end else if (store_room) begin
							count_q <= count_q + cnt_t'(1);
						end
					end
				end
				ST_SCAN: begin
					if (!rd_last) begin
						rd_idx_q <= rd_idx_q + idx_t'(1);
					end
				end
				ST_DRAIN: begin
					rd_idx_q <= pos_q;
				end
				ST_EMIT: begin
					if (!pos_last) begin
						pos_q    <= pos_q + idx_t'(1);
						rd_idx_q <= pos_q + idx_t'(1);
					end
				end
				default: begin
					pos_q <= '0;
				end
			endcase
		end
	end

	// key store
	kse_ram #(
		.DEPTH(MAX_KEYS),
		.WIDTH(KEY_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// minimum search over the unsorted tail
	kse_scan u_scan (
		.clk      (clk),
		.rd_data  (ram_rdata),
		.ctl      (ctl_s1),
		.min_val  (min_val),
		.min_idx  (min_idx),
		.head_val (head_val)
	);

endmodule

>>> hdl/kse_checker.sv
// port-level checker of the key sort engine and its bind to the top level
`timescale 1ns / 1ps

module kse_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic run_end,
	input logic result_valid,
	input logic sorted_end
);
	`include "key_sort_engine_top_assert.svh"

	// results appear only while a run is being sorted
	`KSE_ASSERT_NOW(a_result_busy, result_valid, busy, "result outside sorting")

	// the run end mark rides on a result transaction
	`KSE_ASSERT_NOW(a_end_strobed, sorted_end, result_valid, "sorted_end without result")

	// results never come in consecutive cycles
	`KSE_ASSERT_NEXT(a_result_gap, result_valid, !result_valid, "back-to-back results")

	// the final result frees the engine for the next run
	`KSE_ASSERT_NEXT(a_end_frees, result_valid && sorted_end, !busy, "busy after run end")

	// a key that does not end the run keeps the engine loading
	`KSE_ASSERT_NEXT(a_load_open, start && !busy && !run_end, !busy, "busy during loading")

endmodule

bind key_sort_engine_top kse_checker u_kse_checker (.*);

>>> tb/kse_checker.sv
// checker for the key sort engine: mirrors the run store, predicts sorted output, compares
`timescale 1ns / 1ps

module kse_tb_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  kse_pkg::key_t key_value,
	input  logic          run_end,
	input  logic          result_valid,
	input  kse_pkg::key_t sorted_value,
	input  logic          sorted_end,
	output int            mismatches,
	output int            pending
);
	import kse_pkg::*;

	typedef struct packed {
		key_t value;
		logic last;
	} sorted_item_t;

	// keys of the run being loaded, and sorted results still owed by the block
	key_t         run_keys[$];
	sorted_item_t sorted_expect[$];

	// one line per mismatch, counted
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// ascending insertion sort of the run store
	task automatic sort_run_keys();
		key_t v;
		int   b;
		for (int a = 1; a < run_keys.size(); a++) begin
			v = run_keys[a];
			b = a;
			while (b > 0 && run_keys[b-1] > v) begin
				run_keys[b] = run_keys[b-1];
				b--;
			end
			run_keys[b] = v;
		end
	endtask

	// store the key unless the run is full; on run end queue the sorted run
	task automatic absorb_key(input key_t k, input logic last);
		sorted_item_t item;
		if (run_keys.size() < MAX_KEYS)
			run_keys.push_back(k);
		if (last) begin
			sort_run_keys();
			foreach (run_keys[i]) begin
				item.value = run_keys[i];
				item.last  = (i == run_keys.size() - 1);
				sorted_expect.push_back(item);
			end
			run_keys.delete();
		end
	endtask

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin : watch
		sorted_item_t want;
		if (!arst_n) begin
			run_keys.delete();
			sorted_expect.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (start && !busy)
				absorb_key(key_value, run_end);
			if (result_valid) begin
				if (sorted_expect.size() == 0) begin
					report_mismatch("result with nothing expected, value", sorted_value, 0);
				end else begin
					want = sorted_expect.pop_front();
					if (sorted_value !== want.value)
						report_mismatch("sorted_value", sorted_value, want.value);
					if (sorted_end !== want.last)
						report_mismatch("sorted_end", sorted_end, want.last);
				end
			end
			pending = sorted_expect.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// testbench top for the key sort engine: clock, reset, key stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
	import kse_pkg::*;

	localparam int ITEM_TARGET = 460;
	localparam int STALL_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	key_t key_value;
	logic run_end;
	logic result_valid;
	key_t sorted_value;
	logic sorted_end;

	int   mismatches;
	int   pending;
	int   quiet_cycles = 0;
	logic allow_gaps;

	key_sort_engine_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.key_value   (key_value),
		.run_end     (run_end),
		.result_valid(result_valid),
		.sorted_value(sorted_value),
		.sorted_end  (sorted_end)
	);

	kse_tb_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.key_value   (key_value),
		.run_end     (run_end),
		.result_valid(result_valid),
		.sorted_value(sorted_value),
		.sorted_end  (sorted_end),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	always #5 clk = ~clk;

	// watchdog: too long without any transaction on either side
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// key mix: mostly full range, some duplicates-prone and extreme values
	function automatic key_t pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return key_t'($urandom_range(0, 65535));
		else if (r < 85)
			return key_t'($urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom_range(0, 3));
		else
			return key_t'($urandom_range(0, 1) ? 16'h8000 + $urandom_range(0, 1) : 16'h0100);
	endfunction

	// present one key, with optional leading gaps, and hold it until taken
	task automatic send_key(input key_t k, input logic last);
		while (allow_gaps && $urandom_range(99) < 12) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start     <= 1'b1;
		key_value <= k;
		run_end   <= last;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// stop sending until every owed result has come out
	task automatic drain_results();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	initial begin
		key_t dir_keys [13];
		logic dir_last [13];
		int   sent;
		int   run_idx;
		int   len;
		int   r;

		dir_keys = '{16'h0000, 16'hFFFF,
			16'hFFFF, 16'h0000, 16'h8000, 16'h0100, 16'h7FFF,
			16'h1234, 16'h1234, 16'h0001, 16'h1234,
			16'h0002, 16'h0001};
		dir_last = '{1'b1, 1'b1,
			1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
			1'b0, 1'b0, 1'b0, 1'b1,
			1'b0, 1'b1};

		arst_n     = 1'b0;
		start      = 1'b0;
		key_value  = '0;
		run_end    = 1'b0;
		allow_gaps = 1'b1;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: single-key runs at both extremes, mixed bits, equal keys
		foreach (dir_keys[i])
			send_key(dir_keys[i], dir_last[i]);
		drain_results();

		// random runs: first a full store, one dropped run_end key, one overflow
		sent    = 0;
		run_idx = 0;
		while (sent < ITEM_TARGET - 13) begin
			r = $urandom_range(99);
			if (run_idx == 0)
				len = 64;
			else if (run_idx == 1)
				len = 65;
			else if (run_idx == 2)
				len = 70;
			else if (r < 85)
				len = $urandom_range(1, 10);
			else if (r < 95)
				len = $urandom_range(11, 40);
			else
				len = $urandom_range(0, 4) == 4 ? 70 : $urandom_range(63, 66);

			// a stretch of runs sent back to back
			allow_gaps = !(run_idx >= 20 && run_idx < 34);

			for (int i = 0; i < len; i++) begin
				send_key(pick_key(), i == len - 1);
				sent++;
			end

			if (run_idx % 9 == 4)
				drain_results();
			run_idx++;
		end

		// let everything owed come out, then a short tail
		drain_results();
		repeat (150) @(negedge clk);

		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
